// ===== sv/slen_pkg.sv =====
// ============================================================================
// slen_pkg
// Shared types, codes and microprogram for the sorted list engine.
// ============================================================================
package slen_pkg;

   // default store depth
   localparam int DEF_CAPACITY = 16;

   // field widths
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // request kinds
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISSED   = 3'd5;

   // microprogram steps
   typedef enum logic [4:0] {
      STEP_IDLE,
      STEP_DECODE,
      STEP_INS_INIT,
      STEP_INS_FULL,
      STEP_INS_TEST,
      STEP_INS_CMP,
      STEP_INS_SHIFT,
      STEP_INS_PUT,
      STEP_FIND_INIT,
      STEP_FIND_TEST,
      STEP_FIND_CMP,
      STEP_FIND_NEXT,
      STEP_FIND_MISS,
      STEP_FIND_HIT,
      STEP_DEL_TEST,
      STEP_DEL_MOVE,
      STEP_DEL_DONE,
      STEP_RESP
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_IS_INSERT,
      COND_IS_REMOVE,
      COND_FULL,
      COND_IDX_ZERO,
      COND_IDX_END,
      COND_LAST,
      COND_GREATER,
      COND_EQUAL,
      COND_RSP_TAKEN
   } cond_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LOAD_COUNT,
      IDX_CLEAR,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_PREV,
      RD_CUR,
      RD_NEXT
   } rd_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_RDATA,
      WR_KEY
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      STO_HOLD,
      STO_INSERTED,
      STO_FULL,
      STO_MISS,
      STO_HIT
   } st_op_type;

   // one control word
   typedef struct packed {
      cond_type   cond;
      step_type   tgt_true;
      step_type   tgt_false;
      idx_op_type idx_op;
      rd_op_type  rd_op;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      st_op_type  st_op;
      logic       req_ready;
      logic       rsp_valid;
   } ctrl_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic accept;
      logic is_insert;
      logic is_remove;
      logic full;
      logic idx_zero;
      logic idx_end;
      logic last;
      logic greater;
      logic equal;
      logic rsp_taken;
   } flags_type;

   function automatic ctrl_type cw(
      cond_type cond, step_type tgt_t, step_type tgt_f, idx_op_type idx_op,
      rd_op_type rd_op, wr_op_type wr_op, cnt_op_type cnt_op, st_op_type st_op,
      logic req_ready, logic rsp_valid);
      ctrl_type w;
      w.cond      = cond;
      w.tgt_true  = tgt_t;
      w.tgt_false = tgt_f;
      w.idx_op    = idx_op;
      w.rd_op     = rd_op;
      w.wr_op     = wr_op;
      w.cnt_op    = cnt_op;
      w.st_op     = st_op;
      w.req_ready = req_ready;
      w.rsp_valid = rsp_valid;
      return w;
   endfunction

   // microprogram rom
   function automatic ctrl_type ucode(step_type step);
      ctrl_type w;
      unique case (step)
         STEP_IDLE:      w = cw(COND_ACCEPT, STEP_DECODE, STEP_IDLE, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b1, 1'b0);
         STEP_DECODE:    w = cw(COND_IS_INSERT, STEP_INS_INIT, STEP_FIND_INIT, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_INS_INIT:  w = cw(COND_FULL, STEP_INS_FULL, STEP_INS_TEST, IDX_LOAD_COUNT,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_INS_FULL:  w = cw(COND_ALWAYS, STEP_RESP, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_FULL, 1'b0, 1'b0);
         STEP_INS_TEST:  w = cw(COND_IDX_ZERO, STEP_INS_PUT, STEP_INS_CMP, IDX_HOLD,
                                RD_PREV, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_INS_CMP:   w = cw(COND_GREATER, STEP_INS_SHIFT, STEP_INS_PUT, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_INS_SHIFT: w = cw(COND_ALWAYS, STEP_INS_TEST, STEP_INS_TEST, IDX_DEC,
                                RD_NONE, WR_RDATA, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_INS_PUT:   w = cw(COND_ALWAYS, STEP_RESP, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_KEY, CNT_INC, STO_INSERTED, 1'b0, 1'b0);
         STEP_FIND_INIT: w = cw(COND_ALWAYS, STEP_FIND_TEST, STEP_FIND_TEST, IDX_CLEAR,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_FIND_TEST: w = cw(COND_IDX_END, STEP_FIND_MISS, STEP_FIND_CMP, IDX_HOLD,
                                RD_CUR, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_FIND_CMP:  w = cw(COND_EQUAL, STEP_FIND_HIT, STEP_FIND_NEXT, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_FIND_NEXT: w = cw(COND_ALWAYS, STEP_FIND_TEST, STEP_FIND_TEST, IDX_INC,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_FIND_MISS: w = cw(COND_ALWAYS, STEP_RESP, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_MISS, 1'b0, 1'b0);
         STEP_FIND_HIT:  w = cw(COND_IS_REMOVE, STEP_DEL_TEST, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HIT, 1'b0, 1'b0);
         STEP_DEL_TEST:  w = cw(COND_LAST, STEP_DEL_DONE, STEP_DEL_MOVE, IDX_HOLD,
                                RD_NEXT, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_DEL_MOVE:  w = cw(COND_ALWAYS, STEP_DEL_TEST, STEP_DEL_TEST, IDX_INC,
                                RD_NONE, WR_RDATA, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
         STEP_DEL_DONE:  w = cw(COND_ALWAYS, STEP_RESP, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_DEC, STO_HOLD, 1'b0, 1'b0);
         STEP_RESP:      w = cw(COND_RSP_TAKEN, STEP_IDLE, STEP_RESP, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b1);
         default:        w = cw(COND_ALWAYS, STEP_IDLE, STEP_IDLE, IDX_HOLD,
                                RD_NONE, WR_NONE, CNT_HOLD, STO_HOLD, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

// ===== sv/slen_if.sv =====
// ============================================================================
// slen channel interfaces
// Request and response valid/ready channels of the sorted list engine.
// ============================================================================
interface slen_req_if;
   import slen_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [ACTION_W-1:0] action;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface slen_rsp_if;
   import slen_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== sv/slen_sequencer.sv =====
// ============================================================================
// slen_sequencer
// Step counter and microprogram rom with two-way conditional jumps.
// ============================================================================
module slen_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  slen_pkg::flags_type  flags,
   output slen_pkg::ctrl_type   ctrl
);
   import slen_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_hit;

   // control word of the current step
   always_comb begin
      ctrl = ucode(step_ff);
   end

   // condition select and next step
   always_comb begin
      ctrl_type w;
      w = ucode(step_ff);
      unique case (w.cond)
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_ACCEPT:    cond_hit = flags.accept;
         COND_IS_INSERT: cond_hit = flags.is_insert;
         COND_IS_REMOVE: cond_hit = flags.is_remove;
         COND_FULL:      cond_hit = flags.full;
         COND_IDX_ZERO:  cond_hit = flags.idx_zero;
         COND_IDX_END:   cond_hit = flags.idx_end;
         COND_LAST:      cond_hit = flags.last;
         COND_GREATER:   cond_hit = flags.greater;
         COND_EQUAL:     cond_hit = flags.equal;
         COND_RSP_TAKEN: cond_hit = flags.rsp_taken;
         default:        cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? w.tgt_true : w.tgt_false;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== sv/sorted_list_engine_unit.sv =====
// ============================================================================
// sorted_list_engine_unit
// Bounded sorted multiset with insert, search and remove requests.
// ============================================================================
// Holds up to CAPACITY signed 32-bit values in ascending order in a
// single-port style store (one write and one registered read per cycle),
// driven by a small microprogram. One request is handled at a time and
// answered by exactly one response with a status and the new entry count
// (low 5 bits). Each step of the program makes at most one store access, so
// latency grows with the entries visited. A search walks up from the bottom
// entry until it matches or runs past the last stored entry; an insert moves
// each larger entry up by one, from the top down, before it writes the new
// value, and an insert into a full store makes no store access at all; a
// remove that hits first runs the search and then moves each entry above the
// match down by one, and a remove that misses does only the search. A
// response hold-off delays the response transfer further.
// Store contents are not cleared at reset; only entries below the count are
// ever compared or moved.
module sorted_list_engine_unit #(
   parameter int CAPACITY = slen_pkg::DEF_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   slen_req_if.sink   req_chan,
   slen_rsp_if.source rsp_chan
);
   import slen_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   ctrl_type  ctrl;
   flags_type flags;

   logic signed [VALUE_W-1:0]  mem [CAPACITY];
   logic signed [VALUE_W-1:0]  rdata_ff;
   logic signed [VALUE_W-1:0]  key_ff;
   logic        [ACTION_W-1:0] action_ff;
   logic        [STATUS_W-1:0] status_ff;
   logic        [STATUS_W-1:0] status_in;
   logic        [CNT_W-1:0]    idx_ff;
   logic        [CNT_W-1:0]    idx_in;
   logic        [CNT_W-1:0]    count_ff;
   logic        [CNT_W-1:0]    count_in;
   logic        [CNT_W-1:0]    rd_ptr;
   logic        [CNT_W+4:0]    count_ext;
   logic                       rd_en;
   logic                       wr_en;
   logic signed [VALUE_W-1:0]  wr_data;
   logic                       req_xfer;

   slen_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // handshake
   assign req_chan.ready = ctrl.req_ready;
   assign req_xfer       = req_chan.valid && ctrl.req_ready;
   assign rsp_chan.valid = ctrl.rsp_valid;
   assign rsp_chan.status = status_ff;
   assign count_ext = {5'd0, count_ff};
   assign rsp_chan.entry_count = count_ext[COUNT_W-1:0];

   // flags for the sequencer
   always_comb begin
      flags.accept    = req_xfer;
      flags.is_insert = (action_ff == ACT_INSERT);
      flags.is_remove = (action_ff == ACT_REMOVE);
      flags.full      = (count_ff == CAP_CNT);
      flags.idx_zero  = (idx_ff == '0);
      flags.idx_end   = (idx_ff == count_ff);
      flags.last      = ((idx_ff + ONE_CNT) == count_ff);
      flags.greater   = (rdata_ff > key_ff);
      flags.equal     = (rdata_ff == key_ff);
      flags.rsp_taken = rsp_chan.ready;
   end

   // store read pointer
   always_comb begin
      unique case (ctrl.rd_op)
         RD_PREV: rd_ptr = idx_ff - ONE_CNT;
         RD_NEXT: rd_ptr = idx_ff + ONE_CNT;
         default: rd_ptr = idx_ff;
      endcase
      rd_en = (ctrl.rd_op != RD_NONE);
   end

   // store write data
   always_comb begin
      wr_en   = (ctrl.wr_op != WR_NONE);
      wr_data = (ctrl.wr_op == WR_KEY) ? key_ff : rdata_ff;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_ptr[IDX_W-1:0]];
      end
   end

   // index and count updates
   always_comb begin
      unique case (ctrl.idx_op)
         IDX_LOAD_COUNT: idx_in = count_ff;
         IDX_CLEAR:      idx_in = '0;
         IDX_INC:        idx_in = idx_ff + ONE_CNT;
         IDX_DEC:        idx_in = idx_ff - ONE_CNT;
         default:        idx_in = idx_ff;
      endcase
      unique case (ctrl.cnt_op)
         CNT_INC: count_in = count_ff + ONE_CNT;
         CNT_DEC: count_in = count_ff - ONE_CNT;
         default: count_in = count_ff;
      endcase
   end

   // status selection
   always_comb begin
      unique case (ctrl.st_op)
         STO_INSERTED: status_in = ST_INSERTED;
         STO_FULL:     status_in = ST_FULL;
         STO_MISS:     status_in = (action_ff == ACT_REMOVE) ? ST_MISSED : ST_ABSENT;
         STO_HIT:      status_in = (action_ff == ACT_REMOVE) ? ST_REMOVED : ST_FOUND;
         default:      status_in = status_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      if (req_xfer) begin
         action_ff <= req_chan.action;
         key_ff    <= req_chan.value;
      end
   end

endmodule

// ===== dv/sorted_list_engine_unit_tb.sv =====
// ============================================================================
// sorted_list_engine_unit_tb
// Self-checking bench for the sorted list engine: a shadow sorted store
// predicts status and entry count for every request transfer, and each
// response transfer is checked against the oldest prediction. Directed
// corner requests come first, then random traffic in fill, drain and mixed
// phases, with random idling on both channels, one long response hold-off
// and a few pauses where the sender waits for all responses.
// ============================================================================
module sorted_list_engine_unit_tb;
   import slen_pkg::*;

   localparam int STORE_DEPTH    = DEF_CAPACITY;
   localparam int RANDOM_ITEMS   = 1925;
   localparam int HOLDOFF_AT     = 900;
   localparam int HOLDOFF_CYCLES = 600;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 200;

   // unused request code, answered like a search
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic        [ACTION_W-1:0] action;
      logic signed [VALUE_W-1:0]  value;
      bit                         pause;
   } list_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
   } list_reply_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   logic clock;
   logic reset;

   slen_req_if req_chan ();
   slen_rsp_if rsp_chan ();

   sorted_list_engine_unit #(
      .CAPACITY (STORE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the sorted store
   logic signed [VALUE_W-1:0] shadow_entries [STORE_DEPTH];
   int                        shadow_count;

   list_request_type request_backlog [$];
   list_reply_type   expected_replies [$];

   int items_accepted;
   int results_seen;
   int mismatches;
   int quiet_cycles;

   int  send_wait;
   int  send_calm;
   int  rsp_stall;
   int  rsp_calm;
   bit  holdoff_done;

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one request to the shadow store and return the reply it earns
   function automatic list_reply_type apply_request(input logic [ACTION_W-1:0] act,
                                                    input logic signed [VALUE_W-1:0] val);
      list_reply_type reply;
      int             hit;
      int             pos;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_entries[i] == val) hit = i;
      end
      case (act)
         ACT_INSERT: begin
            if (shadow_count >= STORE_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               // shift larger entries up, then drop the value in
               pos = shadow_count;
               while (pos > 0 && shadow_entries[pos-1] > val) begin
                  shadow_entries[pos] = shadow_entries[pos-1];
                  pos--;
               end
               shadow_entries[pos] = val;
               shadow_count++;
               reply.status = ST_INSERTED;
            end
         end
         ACT_REMOVE: begin
            if (hit < 0) begin
               reply.status = ST_MISSED;
            end else begin
               for (int i = hit; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               reply.status = ST_REMOVED;
            end
         end
         default: begin
            reply.status = (hit >= 0) ? ST_FOUND : ST_ABSENT;
         end
      endcase
      reply.entry_count = COUNT_W'(shadow_count);
      return reply;
   endfunction

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // values cluster in a small pool so that searches and removes hit
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return VALUE_W'($urandom_range(0, 16)) - 32'sd8;
      if (roll < 70) begin
         case ($urandom_range(0, 5))
            0:       return VAL_MIN;
            1:       return VAL_MIN + 32'sd1;
            2:       return VAL_MAX;
            3:       return VAL_MAX - 32'sd1;
            4:       return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(input traffic_mode_type mode);
      int roll;
      int ins_w;
      int srch_w;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin ins_w = 70; srch_w = 12; end
         MODE_DRAIN: begin ins_w = 15; srch_w = 12; end
         default:    begin ins_w = 40; srch_w = 25; end
      endcase
      if (roll < ins_w) return ACT_INSERT;
      if (roll < ins_w + srch_w) return ACT_SEARCH;
      if (roll < 97) return ACT_REMOVE;
      return ACT_SPARE;
   endfunction

   task automatic queue_request(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val);
      list_request_type item;
      item.action = act;
      item.value  = val;
      item.pause  = 1'b0;
      request_backlog.push_back(item);
   endtask

   task automatic queue_pause();
      list_request_type item;
      item.action = ACT_SEARCH;
      item.value  = '0;
      item.pause  = 1'b1;
      request_backlog.push_back(item);
   endtask

   // request driver: sends the backlog, predicts on every transfer
   always @(posedge clock) begin
      list_request_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_replies.push_back(apply_request(req_chan.action, req_chan.value));
            items_accepted++;
         end
         if (send_calm > 0) send_calm--;
         else if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 80);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_chan.valid <= 1'b0;
            end else if (request_backlog.size() > 0 && request_backlog[0].pause) begin
               // hold back until every reply is in
               if (items_accepted == results_seen) void'(request_backlog.pop_front());
               req_chan.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               item = request_backlog.pop_front();
               req_chan.valid  <= 1'b1;
               req_chan.action <= item.action;
               req_chan.value  <= item.value;
               send_wait = (send_calm > 0) ? 0 : pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transfer and paces ready
   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with nothing expected, status %0d count %0d",
                        $time, rsp_chan.status, rsp_chan.entry_count);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, want.entry_count, rsp_chan.entry_count);
                  mismatches++;
               end
            end
            results_seen <= results_seen + 1;
         end
         // one long hold-off while requests keep coming
         if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            rsp_stall    = HOLDOFF_CYCLES;
         end
         if (rsp_calm > 0) rsp_calm--;
         else if ($urandom_range(0, 99) < 2) rsp_calm = $urandom_range(30, 80);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall = (rsp_calm > 0) ? 0 : pick_gap();
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      traffic_mode_type mode;
      int               seg_left;
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.action    = ACT_SEARCH;
      req_chan.value     = '0;
      rsp_chan.ready     = 1'b0;
      shadow_count       = 0;
      items_accepted     = 0;
      results_seen       = 0;
      mismatches         = 0;
      quiet_cycles       = 0;
      send_wait          = 0;
      send_calm          = 0;
      rsp_stall          = 0;
      rsp_calm           = 0;
      holdoff_done       = 1'b0;

      // empty store, spare code, extremes, duplicates, then fill to full
      queue_request(ACT_SEARCH, 32'sd5);
      queue_request(ACT_REMOVE, 32'sd5);
      queue_request(ACT_INSERT, VAL_MAX);
      queue_request(ACT_INSERT, VAL_MIN);
      queue_request(ACT_INSERT, 32'sd0);
      queue_request(ACT_INSERT, 32'sd0);
      queue_request(ACT_INSERT, -32'sd1);
      queue_request(ACT_SEARCH, VAL_MAX);
      queue_request(ACT_SEARCH, VAL_MIN);
      queue_request(ACT_SPARE, 32'sd0);
      queue_request(ACT_SPARE, 32'sd7);
      queue_request(ACT_REMOVE, 32'sd0);
      queue_request(ACT_SEARCH, 32'sd0);
      for (int i = 1; i <= 11; i++) queue_request(ACT_INSERT, 32'sd3 * i - 32'sd10);
      queue_request(ACT_INSERT, 32'sd1);
      queue_pause();

      // random traffic in phases
      mode     = MODE_FILL;
      seg_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            mode     = traffic_mode_type'($urandom_range(0, 2));
            seg_left = $urandom_range(20, 80);
         end
         seg_left--;
         queue_request(pick_action(mode), pick_value());
         if (n == 600 || n == 1400) queue_pause();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_chan.valid ||
             items_accepted != results_seen)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      // every predicted reply must have come back
      if (expected_replies.size() != 0) begin
         $display("%0t: replies missing, expected %0d more, actual 0",
                  $time, expected_replies.size());
         mismatches++;
      end

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/slen_pkg.sv
sv/slen_if.sv
sv/slen_sequencer.sv
sv/sorted_list_engine_unit.sv
dv/sorted_list_engine_unit_tb.sv
